@@ hdl/ghst_pkg.sv @@
`default_nettype none
package ghst_pkg;

    // Table geometry
    localparam int SLOTS           = 64;
    localparam int RESERVED_HANDLE = 1;
    localparam int SLOT_W          = $clog2(SLOTS);
    localparam int IDX_W           = $clog2(SLOTS + 1);
    localparam int GEN_W           = 16;
    localparam int HANDLE_W        = 24;
    localparam int HSLOT_W         = 8;
    localparam int GRP_SIZE        = 8;
    localparam int NGRP            = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W           = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [6:0] MAX_LIST = 7'd64;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_VALIDATE = 2'd2,
        OP_ENUM     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef logic [GEN_W-1:0]    t_gen;
    typedef logic [HANDLE_W-1:0] t_handle;

endpackage
`default_nettype wire

@@ hdl/ghst_ram.sv @@
`default_nettype none
module ghst_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hdl/generational_handle_slot_table_core.sv @@
`default_nettype none
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------------
// command   | start, busy          | i_opcode, i_handle_in, i_list_limit
// result    | o_res_valid (strobe) | o_status, o_handle_out, o_slot_out, o_is_valid,
//           |                      | o_list_count, o_last
//
// A command transfer happens on a rising edge with start high and busy low.
// Free and validate run in S_EXEC; allocate first picks a free slot in S_FIND.
// Enumerate does one generation RAM read per slot walked,
// stopping early once list_limit handles are out.
// Each result shows for one cycle; the receiver cannot stall, so none is held back.
// Reset (synchronous, active low) frees every slot but slot 0 and marks every
// generation as unwritten, which reads as 1; no clearing pass is needed.
module generational_handle_slot_table_core
    import ghst_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [HANDLE_W-1:0] i_handle_in,
    input  wire logic [6:0]          i_list_limit,
    output logic                     o_res_valid,
    output logic [1:0]               o_status,
    output logic [HANDLE_W-1:0]      o_handle_out,
    output logic [5:0]               o_slot_out,
    output logic                     o_is_valid,
    output logic [6:0]               o_list_count,
    output logic                     o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_EXEC,
        S_ENUM
    } t_state;

    // Control state
    t_state             r_state;
    t_op                r_op;
    logic [SLOTS-1:0]   r_live;     // live bit per slot
    logic [SLOTS-1:0]   r_gen_wr;   // generation entry written since reset
    logic [IDX_W-1:0]   r_idx;      // enumerate walk pointer
    logic [6:0]         r_icnt;     // handles issued so far in this enumerate
    logic [6:0]         r_lim;      // clamped list limit
    logic               r_p1_v;     // listed slot read in flight
    logic               r_h_v;      // listed handle held back for the last flag

    // Payload
    t_handle            r_handle;
    logic [SLOT_W-1:0]  r_rd_slot;  // slot whose generation is on the RAM output
    logic [6:0]         r_p1_cnt;
    t_handle            r_h_handle;
    logic [6:0]         r_h_cnt;
    logic               r_grp_any [NGRP];
    logic [2:0]         r_grp_low [NGRP];

    // Registered result
    logic               r_o_valid;
    t_status            r_o_status;
    t_handle            r_o_handle;
    logic [5:0]         r_o_slot;
    logic               r_o_is_valid;
    logic [6:0]         r_o_count;
    logic               r_o_last;

    // Combinational helpers
    logic [NGRP*GRP_SIZE-1:0] free_pad;
    logic               grp_any [NGRP];
    logic [2:0]         grp_low [NGRP];
    logic               pick_found;
    logic [GRP_W-1:0]   pick_g;
    logic [SLOT_W-1:0]  pick_slot;
    logic [SLOT_W-1:0]  rd_addr;
    t_gen               ram_q;
    t_gen               gen_eff;
    t_gen               gen_inc;
    t_gen               gen_next;
    logic [HSLOT_W-1:0] h_slot;
    t_gen               h_gen;
    logic               h_in_range;
    logic               h_is_res;
    logic               h_live_ok;
    logic               h_valid;
    logic               free_ok;
    logic               ram_we;
    logic               can_issue;
    logic               listed;
    t_handle            p1_handle;
    logic [6:0]         lim_clamp;

    // Free-slot search, first level: lowest free bit in each group of eight
    always_comb begin
        free_pad = '0;
        free_pad[SLOTS-1:0] = ~r_live;
        free_pad[0] = 1'b0;
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = |free_pad[g*GRP_SIZE +: GRP_SIZE];
            grp_low[g] = 3'd0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (free_pad[g*GRP_SIZE + b]) begin
                    grp_low[g] = 3'(b);
                end
            end
        end
    end

    // Second level: lowest group with a free slot, from the registered flags
    always_comb begin
        pick_found = 1'b0;
        pick_g     = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                pick_found = 1'b1;
                pick_g     = GRP_W'(g);
            end
        end
        pick_slot = SLOT_W'({pick_g, r_grp_low[pick_g]});
    end

    // Generation RAM read address
    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = i_handle_in[SLOT_W-1:0];
            S_FIND:  rd_addr = pick_slot;
            S_ENUM:  rd_addr = r_idx[SLOT_W-1:0];
            default: rd_addr = r_rd_slot;
        endcase
    end

    // An entry never written since reset reads as generation 1
    assign gen_eff  = r_gen_wr[r_rd_slot] ? ram_q : t_gen'(1);
    assign gen_inc  = gen_eff + t_gen'(1);
    assign gen_next = (gen_inc == '0) ? t_gen'(1) : gen_inc;

    // Handle checks for free and validate
    assign h_slot     = r_handle[HSLOT_W-1:0];
    assign h_gen      = r_handle[HANDLE_W-1:HSLOT_W];
    assign h_in_range = ({1'b0, h_slot} < 9'(SLOTS));
    assign h_is_res   = (r_handle == t_handle'(RESERVED_HANDLE));
    assign h_live_ok  = h_in_range && (h_slot != '0) && r_live[r_handle[SLOT_W-1:0]]
                        && (gen_eff == h_gen);
    assign h_valid    = h_is_res || h_live_ok;
    assign free_ok    = !h_is_res && h_live_ok;

    assign ram_we = (r_state == S_EXEC) && (r_op == OP_FREE) && free_ok;

    // Enumerate: liveness is known at issue, only the generation comes from RAM
    assign can_issue = (r_idx < IDX_W'(SLOTS)) && (r_icnt < r_lim);
    assign listed    = r_live[r_idx[SLOT_W-1:0]]
                       && !((r_idx == '0) && (RESERVED_HANDLE == 0));
    assign p1_handle = (r_rd_slot == '0) ? t_handle'(RESERVED_HANDLE)
                                         : {gen_eff, HSLOT_W'(r_rd_slot)};
    assign lim_clamp = (i_list_limit > MAX_LIST) ? MAX_LIST : i_list_limit;

    ghst_ram #(
        .WIDTH (GEN_W),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rd_slot),
        .i_wdata (gen_next),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        r_rd_slot <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_ALLOC;
            r_live    <= SLOTS'(1);
            r_gen_wr  <= '0;
            r_idx     <= '0;
            r_icnt    <= '0;
            r_lim     <= '0;
            r_p1_v    <= 1'b0;
            r_h_v     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_o_valid <= 1'b0;
                    if (start) begin
                        r_op     <= t_op'(i_opcode);
                        r_handle <= i_handle_in;
                        case (t_op'(i_opcode))
                            OP_ALLOC: begin
                                // Latch the per-group flags, pick next cycle
                                for (int g = 0; g < NGRP; g++) begin
                                    r_grp_any[g] <= grp_any[g];
                                    r_grp_low[g] <= grp_low[g];
                                end
                                r_state <= S_FIND;
                            end
                            OP_ENUM: begin
                                r_idx   <= '0;
                                r_icnt  <= '0;
                                r_lim   <= lim_clamp;
                                r_p1_v  <= 1'b0;
                                r_h_v   <= 1'b0;
                                r_state <= S_ENUM;
                            end
                            default: begin
                                r_state <= S_EXEC;
                            end
                        endcase
                    end
                end

                S_FIND: begin
                    if (pick_found) begin
                        r_o_valid         <= 1'b0;
                        r_live[pick_slot] <= 1'b1;
                        r_state           <= S_EXEC;
                    end else begin
                        // Pool exhausted
                        r_o_valid    <= 1'b1;
                        r_o_status   <= ST_EXHAUSTED;
                        r_o_handle   <= '0;
                        r_o_slot     <= '0;
                        r_o_is_valid <= 1'b0;
                        r_o_count    <= '0;
                        r_o_last     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                S_EXEC: begin
                    r_o_valid <= 1'b1;
                    r_o_count <= '0;
                    r_o_last  <= 1'b1;
                    r_state   <= S_IDLE;
                    case (r_op)
                        OP_ALLOC: begin
                            r_o_status   <= ST_OK;
                            r_o_handle   <= {gen_eff, HSLOT_W'(r_rd_slot)};
                            r_o_slot     <= 6'(r_rd_slot);
                            r_o_is_valid <= 1'b0;
                        end
                        OP_FREE: begin
                            r_o_handle   <= '0;
                            r_o_slot     <= '0;
                            r_o_is_valid <= 1'b0;
                            if (free_ok) begin
                                // Release the slot and bump its generation
                                r_live[r_rd_slot]   <= 1'b0;
                                r_gen_wr[r_rd_slot] <= 1'b1;
                                r_o_status          <= ST_OK;
                            end else begin
                                r_o_status <= ST_INVALID;
                            end
                        end
                        default: begin
                            r_o_handle   <= '0;
                            r_o_slot     <= '0;
                            r_o_status   <= h_valid ? ST_OK : ST_INVALID;
                            r_o_is_valid <= h_valid;
                        end
                    endcase
                end

                S_ENUM: begin
                    if (can_issue) begin
                        r_idx  <= r_idx + IDX_W'(1);
                        r_p1_v <= listed;
                        if (listed) begin
                            r_icnt   <= r_icnt + 7'd1;
                            r_p1_cnt <= r_icnt + 7'd1;
                        end
                    end else begin
                        r_p1_v <= 1'b0;
                    end

                    if (r_p1_v) begin
                        // A later handle exists, so the held one is not last
                        r_o_valid <= r_h_v;
                        if (r_h_v) begin
                            r_o_status   <= ST_OK;
                            r_o_handle   <= r_h_handle;
                            r_o_slot     <= '0;
                            r_o_is_valid <= 1'b0;
                            r_o_count    <= r_h_cnt;
                            r_o_last     <= 1'b0;
                        end
                        r_h_v      <= 1'b1;
                        r_h_handle <= p1_handle;
                        r_h_cnt    <= r_p1_cnt;
                    end else if (!can_issue) begin
                        // Walk finished and drained: flush the held handle as last
                        r_o_valid    <= 1'b1;
                        r_o_status   <= ST_OK;
                        r_o_handle   <= r_h_v ? r_h_handle : '0;
                        r_o_slot     <= '0;
                        r_o_is_valid <= 1'b0;
                        r_o_count    <= r_h_v ? r_h_cnt : 7'd0;
                        r_o_last     <= 1'b1;
                        r_h_v        <= 1'b0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_o_valid <= 1'b0;
                    end
                end

                default: begin
                    r_o_valid <= 1'b0;
                    r_state   <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_res_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_handle_out = r_o_handle;
    assign o_slot_out   = r_o_slot;
    assign o_is_valid   = r_o_is_valid;
    assign o_list_count = r_o_count;
    assign o_last       = r_o_last;

    // Slot 0 stays live whatever is freed
    a_slot0_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live[0])
        else $error("slot 0 lost its live bit");

    // A final result leaves the block ready for the next command
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_last) |-> !busy)
        else $error("final result while still busy");

    // A result that is not final means more of the same command follow
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_last) |-> busy)
        else $error("intermediate result without a command in progress");

    // Enumerate never lists beyond its limit
    a_enum_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENUM) |-> (r_icnt <= r_lim))
        else $error("enumerate count passed the limit");

    // A transfer on the command side always starts work
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

endmodule
`default_nettype wire

@@ verif/tb_generational_handle_slot_table_core.sv @@
`timescale 1ns / 1ps

module tb_generational_handle_slot_table_core;
    import ghst_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 9;
    // The longest correct silence is an enumerate walk plus a long sender gap.
    localparam int IDLE_LIMIT = 1000;
    localparam int RAND_ITEMS = 300;
    localparam int CHURN      = 8;
    localparam int TAIL_WAIT  = SLOTS + 16;
    localparam int MAX_PRINTS = 40;

    // One command as the sender presents it.
    typedef struct {
        t_op             op;
        t_handle         h;
        logic [6:0]      lim;
    } cmd_t;

    // One result as the block should present it.
    typedef struct {
        logic [1:0]      status;
        t_handle         handle;
        logic [5:0]      slot;
        logic            valid;
        logic [6:0]      count;
        logic            last;
    } res_t;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic [1:0]          i_opcode     = OP_ALLOC;
    logic [HANDLE_W-1:0] i_handle_in  = '0;
    logic [6:0]          i_list_limit = '0;
    logic                busy;
    logic                o_res_valid;
    logic [1:0]          o_status;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [5:0]          o_slot_out;
    logic                o_is_valid;
    logic [6:0]          o_list_count;
    logic                o_last;

    // Shadow of the slot table, updated on every command transfer.
    bit   live_map [SLOTS];
    t_gen gen_tab  [SLOTS];

    cmd_t cmd_q [$];        // commands still to be offered
    res_t res_expect_q [$]; // results owed by the block, oldest first

    int   items_queued = 0;
    int   items_taken  = 0;
    int   err_cnt      = 0;
    int   idle_cnt     = 0;
    int   gap_left     = 0;
    bit   gaps_on      = 1'b1;
    logic cmd_xfer     = 1'b0;

    generational_handle_slot_table_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_handle_in  (i_handle_in),
        .i_list_limit (i_list_limit),
        .o_res_valid  (o_res_valid),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_slot_out   (o_slot_out),
        .o_is_valid   (o_is_valid),
        .o_list_count (o_list_count),
        .o_last       (o_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Table state after reset: slot 0 live, every generation at 1.
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            live_map[i] = 1'b0;
            gen_tab[i]  = t_gen'(1);
        end
        live_map[0] = 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("%0t mismatch, %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic res_t mk_res(logic [1:0] status, t_handle handle, logic [5:0] slot,
                                    logic valid, logic [6:0] count, logic last);
        res_t r;
        r.status = status;
        r.handle = handle;
        r.slot   = slot;
        r.valid  = valid;
        r.count  = count;
        r.last   = last;
        return r;
    endfunction

    // A handle is good when it is the reserved one, or names a live slot in
    // range (never slot 0) with a matching generation.
    function automatic bit handle_live(t_handle h);
        logic [HSLOT_W-1:0] s;
        s = h[HSLOT_W-1:0];
        if (h == t_handle'(RESERVED_HANDLE))
            return 1'b1;
        if (s == 0 || s >= SLOTS)
            return 1'b0;
        return live_map[s[SLOT_W-1:0]] && gen_tab[s[SLOT_W-1:0]] == h[HANDLE_W-1:HSLOT_W];
    endfunction

    // Apply one accepted command to the shadow table and queue the results it owes.
    task automatic table_apply(input cmd_t c);
        t_handle            found [SLOTS];
        t_handle            hv;
        t_gen               ng;
        logic [SLOT_W-1:0]  s;
        int                 n;
        int                 lim_n;
        bit                 hit;
        hit = 1'b0;
        n   = 0;
        s   = c.h[SLOT_W-1:0];
        case (c.op)
            OP_ALLOC: begin
                for (int i = 1; i < SLOTS && !hit; i++) begin
                    if (!live_map[i]) begin
                        live_map[i] = 1'b1;
                        hv = {gen_tab[i], 8'(i)};
                        res_expect_q.push_back(mk_res(ST_OK, hv, 6'(i), 1'b0, 7'd0, 1'b1));
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    res_expect_q.push_back(mk_res(ST_EXHAUSTED, '0, '0, 1'b0, 7'd0, 1'b1));
            end
            OP_FREE: begin
                if (c.h == t_handle'(RESERVED_HANDLE) || !handle_live(c.h)) begin
                    res_expect_q.push_back(mk_res(ST_INVALID, '0, '0, 1'b0, 7'd0, 1'b1));
                end else begin
                    live_map[s] = 1'b0;
                    // bump the generation, skipping 0 on wrap
                    ng = gen_tab[s] + t_gen'(1);
                    if (ng == '0)
                        ng = t_gen'(1);
                    gen_tab[s] = ng;
                    res_expect_q.push_back(mk_res(ST_OK, '0, '0, 1'b0, 7'd0, 1'b1));
                end
            end
            OP_VALIDATE: begin
                if (handle_live(c.h))
                    res_expect_q.push_back(mk_res(ST_OK, '0, '0, 1'b1, 7'd0, 1'b1));
                else
                    res_expect_q.push_back(mk_res(ST_INVALID, '0, '0, 1'b0, 7'd0, 1'b1));
            end
            default: begin
                lim_n = (c.lim > MAX_LIST) ? int'(MAX_LIST) : int'(c.lim);
                for (int i = 0; i < SLOTS && n < lim_n; i++) begin
                    if (live_map[i]) begin
                        hv = (i == 0) ? t_handle'(RESERVED_HANDLE) : {gen_tab[i], 8'(i)};
                        if (hv != '0) begin
                            found[n] = hv;
                            n++;
                        end
                    end
                end
                if (n == 0)
                    res_expect_q.push_back(mk_res(ST_OK, '0, '0, 1'b0, 7'd0, 1'b1));
                for (int k = 0; k < n; k++)
                    res_expect_q.push_back(mk_res(ST_OK, found[k], '0, 1'b0, 7'(k + 1),
                                                  k == n - 1));
            end
        endcase
    endtask

    task automatic push_cmd(input t_op op, input t_handle h, input logic [6:0] lim);
        cmd_t c;
        c.op  = op;
        c.h   = h;
        c.lim = lim;
        cmd_q.push_back(c);
        items_queued++;
    endtask

    // Hold until every queued command has been taken and every owed result has come.
    task automatic wait_drained();
        while (items_taken != items_queued || res_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: change inputs on the falling edge only. Keep start high until the
    // transfer happens, then idle for a random gap or present the next command.
    always @(negedge i_clk) begin : drv
        logic nxt_start;
        cmd_t c;
        int   r;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!start || cmd_xfer) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                i_opcode     <= c.op;
                i_handle_in  <= c.h;
                i_list_limit <= c.lim;
                nxt_start    = 1'b1;
                // most gaps short, a few long, many none at all
                r = $urandom_range(0, 99);
                if (!gaps_on || r < 55)
                    gap_left = 0;
                else if (r < 90)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(8, 40);
            end
        end
        start <= nxt_start;
    end

    // Monitor: sample on the rising edge. Check each result strobe against the
    // oldest expectation, and run the shadow table on each command transfer.
    always @(posedge i_clk) begin : mon
        res_t want;
        cmd_t got_cmd;
        if (i_rst_n) begin
            if (o_res_valid === 1'b1) begin
                if (res_expect_q.size() == 0) begin
                    report_mismatch("result with nothing owed", 32'(o_handle_out), '0);
                end else begin
                    want = res_expect_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_handle_out !== want.handle)
                        report_mismatch("handle_out", 32'(o_handle_out), 32'(want.handle));
                    if (o_slot_out !== want.slot)
                        report_mismatch("slot_out", 32'(o_slot_out), 32'(want.slot));
                    if (o_is_valid !== want.valid)
                        report_mismatch("is_valid", 32'(o_is_valid), 32'(want.valid));
                    if (o_list_count !== want.count)
                        report_mismatch("list_count", 32'(o_list_count), 32'(want.count));
                    if (o_last !== want.last)
                        report_mismatch("last", 32'(o_last), 32'(want.last));
                end
            end
            if (start && busy === 1'b0) begin
                got_cmd.op  = t_op'(i_opcode);
                got_cmd.h   = i_handle_in;
                got_cmd.lim = i_list_limit;
                table_apply(got_cmd);
                items_taken++;
            end
        end
        cmd_xfer <= i_rst_n && start && busy === 1'b0;
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_res_valid === 1'b1)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stim
        int      rand_cnt;
        int      batch;
        int      mode;
        int      r;
        int      s;
        t_gen    g;
        t_gen    gm;
        t_handle h;
        t_op     op;
        logic [6:0] lim;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reserved handle, slot zero, out-of-range slot, empty and
        // clipped enumerates, stale and dead handles, all-ones handle.
        push_cmd(OP_VALIDATE, t_handle'(RESERVED_HANDLE), 7'd0);
        push_cmd(OP_FREE,     t_handle'(RESERVED_HANDLE), 7'd0);
        push_cmd(OP_VALIDATE, 24'h000000, 7'd0);
        push_cmd(OP_VALIDATE, 24'h000100, 7'd0);
        push_cmd(OP_FREE,     24'h000100, 7'd0);
        push_cmd(OP_VALIDATE, 24'h000140, 7'd0);
        push_cmd(OP_FREE,     24'h0001FF, 7'd0);
        push_cmd(OP_ENUM,     24'h000000, 7'd0);
        push_cmd(OP_ENUM,     24'h000000, 7'd127);
        push_cmd(OP_ALLOC,    24'h000000, 7'd0);
        push_cmd(OP_ALLOC,    24'hFFFFFF, 7'd127);
        push_cmd(OP_ALLOC,    24'h000000, 7'd0);
        push_cmd(OP_VALIDATE, 24'h000101, 7'd0);
        push_cmd(OP_FREE,     24'h000102, 7'd0);
        push_cmd(OP_VALIDATE, 24'h000102, 7'd0);
        push_cmd(OP_FREE,     24'h000102, 7'd0);
        push_cmd(OP_FREE,     24'h000203, 7'd0);
        push_cmd(OP_ALLOC,    24'h000000, 7'd0);
        push_cmd(OP_VALIDATE, 24'hFFFFFF, 7'd0);
        push_cmd(OP_FREE,     24'hFFFFFF, 7'd0);
        push_cmd(OP_ENUM,     24'h000000, 7'd2);
        push_cmd(OP_ENUM,     24'hFFFFFF, 7'd64);
        wait_drained();

        // Churn the lowest free slot: allocate and free it a few times so its
        // generation advances and older handles go stale. Run flat out, no gaps.
        gaps_on = 1'b0;
        s = 1;
        while (s < SLOTS - 1 && live_map[s])
            s++;
        g = gen_tab[s];
        for (int k = 0; k < CHURN; k++) begin
            push_cmd(OP_ALLOC, '0, 7'd0);
            push_cmd(OP_FREE, {g, 8'(s)}, 7'd0);
            g = (g == '1) ? t_gen'(1) : t_gen'(g + t_gen'(1));
        end
        push_cmd(OP_VALIDATE, {16'hFFFF, 8'(s)}, 7'd0);
        push_cmd(OP_ALLOC, '0, 7'd0);
        push_cmd(OP_VALIDATE, {g, 8'(s)}, 7'd0);
        push_cmd(OP_VALIDATE, {16'hFFFF, 8'(s)}, 7'd0);
        wait_drained();

        // Fill the pool, run past exhaustion, then list the full table.
        gaps_on = 1'b1;
        for (int k = 0; k < SLOTS + 2; k++)
            push_cmd(OP_ALLOC, t_handle'($urandom), 7'($urandom));
        push_cmd(OP_ENUM, '0, MAX_LIST);
        push_cmd(OP_ENUM, '0, 7'd100);
        wait_drained();

        // Random batches. Each batch is built from the table as it stands after
        // the last one drained, so most frees and validates name real handles;
        // later items in a batch may find them gone, which is wanted too.
        rand_cnt = 0;
        while (rand_cnt < RAND_ITEMS) begin
            batch   = $urandom_range(1, 30);
            mode    = $urandom_range(0, 2);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < batch; k++) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0:       op = (r < 60) ? OP_ALLOC : (r < 75) ? OP_FREE :
                                  (r < 90) ? OP_VALIDATE : OP_ENUM;
                    1:       op = (r < 15) ? OP_ALLOC : (r < 65) ? OP_FREE :
                                  (r < 90) ? OP_VALIDATE : OP_ENUM;
                    default: op = (r < 30) ? OP_ALLOC : (r < 60) ? OP_FREE :
                                  (r < 85) ? OP_VALIDATE : OP_ENUM;
                endcase
                // probe a few times for a live slot
                s = $urandom_range(1, SLOTS - 1);
                for (int p = 0; p < 8 && !live_map[s]; p++)
                    s = $urandom_range(1, SLOTS - 1);
                gm = gen_tab[s] - t_gen'(1);
                r = $urandom_range(0, 99);
                if (r < 55)
                    h = {gen_tab[s], 8'(s)};
                else if (r < 65)
                    h = {gm, 8'(s)};
                else if (r < 70)
                    h = t_handle'(RESERVED_HANDLE);
                else if (r < 75)
                    h = {16'($urandom), 8'd0};
                else if (r < 80)
                    h = {16'($urandom), 8'($urandom_range(SLOTS, 255))};
                else
                    h = t_handle'($urandom);
                lim = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 127)) :
                                                   7'($urandom_range(0, 4));
                push_cmd(op, h, lim);
                rand_cnt++;
            end
            wait_drained();
        end

        // Let any stray result show before judging.
        repeat (TAIL_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
